// File: design/afr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

	// Receiver phase. The unused codes five to seven behave as idle.
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_LEN_HI  = 3'd1,
		PH_LEN_LO  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CHECK   = 3'd4
	} phase_t;

	// Result kind reported with each output request.
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_GOOD = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	localparam int unsigned BYTE_BITS = 8;
	localparam int unsigned LEN_BITS  = 2 * BYTE_BITS;

	// A good frame has payload sum plus checksum equal to all ones.
	localparam logic [BYTE_BITS-1:0] SUM_GOOD = 8'hFF;

	localparam logic [BYTE_BITS-1:0] DELIM_RESET = 8'h7E;

endpackage

`default_nettype wire

// File: design/api_frame_receiver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Data path: an accepted byte is loaded into the input register, and any result it makes is then
// loaded into the result register when the parser consumes the byte.
// Throughput: one byte per cycle; the input register and the output register each hold one
// request, so the input side stalls only while a result waits and the output is blocked.
// Reset (arst_n low, asynchronous): frame parser idle, both registers empty, start delimiter 0x7E.

module api_frame_receiver_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,

	// Received byte channel.
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,

	// Result channel.
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      data_byte,
	output logic [1:0]      kind,

	// Configuration channel: writes the start delimiter.
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] start_delimiter
);

	// Start delimiter register. Writes are only expected while the block is idle,
	// so the port can always take them.
	logic [afr_pkg::BYTE_BITS-1:0] delim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= afr_pkg::DELIM_RESET;
		end else if (cfg_valid) begin
			delim_q <= start_delimiter;
		end
	end

	// Input register. It holds one received byte until the parser consumes it.
	logic                          valid_s1;
	logic [afr_pkg::BYTE_BITS-1:0] rx_byte_s1;
	logic                          advance;
	logic                          out_free;

	// The result register can take a new request when it is empty or being drained.
	assign out_free = !out_valid || out_ready;
	// The parser consumes the held byte whenever the result register has room.
	// Bytes that make no result still wait for room, which keeps the control simple.
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// Frame parser state.
	afr_pkg::phase_t               phase_q;
	afr_pkg::phase_t               phase_d;
	logic [afr_pkg::LEN_BITS-1:0]  frame_length_q;
	logic [afr_pkg::LEN_BITS-1:0]  frame_length_d;
	logic [afr_pkg::LEN_BITS-1:0]  byte_count_q;
	logic [afr_pkg::LEN_BITS-1:0]  byte_count_d;
	logic [afr_pkg::BYTE_BITS-1:0] running_sum_q;
	logic [afr_pkg::BYTE_BITS-1:0] running_sum_d;

	// Result produced by the byte in the input register.
	logic                          res_valid;
	afr_pkg::kind_t                res_kind;
	logic [afr_pkg::BYTE_BITS-1:0] check_total;
	logic [afr_pkg::LEN_BITS-1:0]  count_inc;
	logic [afr_pkg::LEN_BITS-1:0]  length_full;

	assign check_total = running_sum_q + rx_byte_s1;
	assign count_inc   = byte_count_q + afr_pkg::LEN_BITS'(1);
	// Low length byte merged into the stored high byte.
	assign length_full = {frame_length_q[afr_pkg::LEN_BITS-1:afr_pkg::BYTE_BITS], rx_byte_s1};

	always_comb begin
		phase_d        = phase_q;
		frame_length_d = frame_length_q;
		byte_count_d   = byte_count_q;
		running_sum_d  = running_sum_q;
		res_valid      = 1'b0;
		res_kind       = afr_pkg::KIND_DATA;
		unique case (phase_q)
			afr_pkg::PH_LEN_HI: begin
				frame_length_d = {rx_byte_s1, {afr_pkg::BYTE_BITS{1'b0}}};
				phase_d        = afr_pkg::PH_LEN_LO;
			end
			afr_pkg::PH_LEN_LO: begin
				frame_length_d = length_full;
				// A zero length frame goes straight to its checksum byte.
				if (length_full == '0) begin
					phase_d = afr_pkg::PH_CHECK;
				end else begin
					phase_d = afr_pkg::PH_PAYLOAD;
				end
			end
			afr_pkg::PH_PAYLOAD: begin
				running_sum_d = check_total;
				byte_count_d  = count_inc;
				if (count_inc == frame_length_q) begin
					phase_d = afr_pkg::PH_CHECK;
				end
				res_valid = 1'b1;
			end
			afr_pkg::PH_CHECK: begin
				res_valid = 1'b1;
				if (check_total == afr_pkg::SUM_GOOD) begin
					res_kind = afr_pkg::KIND_GOOD;
				end else begin
					res_kind = afr_pkg::KIND_BAD;
				end
				phase_d = afr_pkg::PH_IDLE;
			end
			default: begin
				// Idle, and any unused phase code: hunt for the start delimiter.
				if (rx_byte_s1 == delim_q) begin
					phase_d       = afr_pkg::PH_LEN_HI;
					byte_count_d  = '0;
					running_sum_d = '0;
				end else begin
					phase_d = afr_pkg::PH_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= afr_pkg::PH_IDLE;
			frame_length_q <= '0;
			byte_count_q   <= '0;
			running_sum_q  <= '0;
		end else if (advance) begin
			phase_q        <= phase_d;
			frame_length_q <= frame_length_d;
			byte_count_q   <= byte_count_d;
			running_sum_q  <= running_sum_d;
		end
	end

	// Result register.
	logic                          out_valid_q;
	logic [afr_pkg::BYTE_BITS-1:0] data_byte_q;
	afr_pkg::kind_t                kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			data_byte_q <= rx_byte_s1;
			kind_q      <= res_kind;
		end
	end

	assign out_valid = out_valid_q;
	assign data_byte = data_byte_q;
	assign kind      = kind_q;

	// A matching delimiter seen while idle opens a frame.
	a_delim_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == afr_pkg::PH_IDLE && rx_byte_s1 == delim_q)
		|=> (phase_q == afr_pkg::PH_LEN_HI))
		else $error("delimiter did not open a frame");

	// The checksum byte always yields a result and returns the parser to idle.
	a_check_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == afr_pkg::PH_CHECK)
		|=> (phase_q == afr_pkg::PH_IDLE && out_valid_q && kind_q != afr_pkg::KIND_DATA))
		else $error("checksum byte did not end the frame");

	// Within the payload the byte count stays below the frame length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == afr_pkg::PH_PAYLOAD) |-> (byte_count_q < frame_length_q))
		else $error("payload byte count overran the frame length");

	// A reported result always carries a defined kind.
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (kind_q == afr_pkg::KIND_DATA || kind_q == afr_pkg::KIND_GOOD
			|| kind_q == afr_pkg::KIND_BAD))
		else $error("result kind out of range");

endmodule

`default_nettype wire
